// ===== sv/odve_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// odve_pkg
// Shared types and constants of the offset delta variable-length encoder.
// ----------------------------------------------------------------------------
package odve_pkg;

    // Width of the position arithmetic; positions are reduced to this width.
    localparam int POSITION_WIDTH = 32;
    localparam int FIELD_WIDTH    = 32;
    localparam int QUOT_WIDTH     = 30;

    // Largest quotient that each encoding length can carry.
    localparam logic [63:0] QUOT_ONE_MAX  = 64'h3F;
    localparam logic [63:0] QUOT_TWO_MAX  = 64'h3FFF;
    localparam logic [63:0] QUOT_FOUR_MAX = 64'h3FFF_FFFF;

    // Size markers in the top two bits of the first byte.
    localparam logic [1:0] MARK_ONE  = 2'b01;
    localparam logic [1:0] MARK_TWO  = 2'b10;
    localparam logic [1:0] MARK_FOUR = 2'b11;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] field_position;
        logic                   first_of_table;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       last_byte;
        logic       range_error;
    } out_beat_t;

    typedef enum logic [1:0] {
        KIND_ONE,
        KIND_TWO,
        KIND_FOUR,
        KIND_ERROR
    } enc_kind_t;

    typedef struct packed {
        enc_kind_t              kind;
        logic [QUOT_WIDTH-1:0]  quotient;
    } enc_entry_t;

    // Full and empty status of the queue, seen by both of its neighbours.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage : odve_pkg
`default_nettype wire

// ===== sv/offset_delta_varlen_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// offset_delta_varlen_encoder
// Turns ascending pointer-field positions into a variable-length offset table.
// ----------------------------------------------------------------------------
// Usage. Each input beat carries a byte position and a flag marking the first
// position of a table. The block takes the distance from the previous accepted
// position, or from the base position register for a table's first entry,
// drops its two low bits and sends the quotient as one, two or four bytes,
// most significant first, with a size marker in the top two bits of the first
// byte. Each output beat is one table byte; last_byte marks an item's final
// byte. A negative distance or an oversized quotient gives a single beat with
// range_error set, and the previous position is then kept.
// The base position is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while idle, which the block does not enforce.
// Throughput is one output byte per cycle, set by the back end's serialiser,
// while out_stall is low and items wait; an item is one, two or four bytes.
// A two-entry queue parts the classifying front end from the serialiser, so
// input beats keep being taken while output bytes wait under out_stall; the
// input stalls only when the queue is full. Reset clears the base and previous
// positions to zero and empties the queue and output stage.
// ----------------------------------------------------------------------------
module offset_delta_varlen_encoder
    import odve_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [FIELD_WIDTH-1:0] cfg_wr_data,
    input  wire logic                   in_valid,
    output      logic                   in_stall,
    input  wire in_beat_t               in_beat,
    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      out_beat_t              out_beat
);

    queue_status_t q_status;
    logic          q_push;
    enc_entry_t    q_push_entry;
    logic          q_pop;
    enc_entry_t    q_pop_entry;

    // The front end classifies each beat and tracks the previous position.
    odve_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_beat      (in_beat),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_push_entry (q_push_entry)
    );

    // The queue holds classified items until the serialiser is ready.
    odve_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .pop_entry  (q_pop_entry),
        .status     (q_status)
    );

    // The back end sends one byte per cycle from the registered item while out_stall is low.
    odve_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_pop_entry (q_pop_entry),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_beat    (out_beat)
    );

endmodule : offset_delta_varlen_encoder
`default_nettype wire

// ===== sv/odve_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// odve_front
// Accepts positions, forms the delta and classifies it into an encoding.
// ----------------------------------------------------------------------------
module odve_front
    import odve_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic [FIELD_WIDTH-1:0]  cfg_wr_data,
    input  wire logic                    in_valid,
    output      logic                    in_stall,
    input  wire in_beat_t                in_beat,
    input  wire queue_status_t           q_status,
    output      logic                    q_push,
    output      enc_entry_t              q_push_entry
);

    logic [POSITION_WIDTH-1:0] base_reg;
    logic [POSITION_WIDTH-1:0] base_next;
    logic [POSITION_WIDTH-1:0] prev_reg;
    logic [POSITION_WIDTH-1:0] prev_next;
    logic [POSITION_WIDTH-1:0] pos;
    logic [POSITION_WIDTH-1:0] ref_pos;
    logic [POSITION_WIDTH:0]   diff;
    logic [63:0]               quot;
    logic                      accept;
    logic                      is_error;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    always_comb
    begin
        pos     = POSITION_WIDTH'(in_beat.field_position);
        ref_pos = in_beat.first_of_table ? base_reg : prev_reg;
        diff    = {1'b0, pos} - {1'b0, ref_pos};
        quot    = 64'(diff[POSITION_WIDTH-1:2]);

        q_push_entry.quotient = QUOT_WIDTH'(quot);
        is_error = 1'b0;
        if (diff[POSITION_WIDTH])
        begin
            is_error = 1'b1;
        end
        else if (quot > QUOT_FOUR_MAX)
        begin
            is_error = 1'b1;
        end

        if (is_error)
        begin
            q_push_entry.kind = KIND_ERROR;
        end
        else if (quot <= QUOT_ONE_MAX)
        begin
            q_push_entry.kind = KIND_ONE;
        end
        else if (quot <= QUOT_TWO_MAX)
        begin
            q_push_entry.kind = KIND_TWO;
        end
        else
        begin
            q_push_entry.kind = KIND_FOUR;
        end

        q_push = accept;

        prev_next = prev_reg;
        if (accept && !is_error)
        begin
            prev_next = pos;
        end

        base_next = base_reg;
        if (cfg_wr_en)
        begin
            base_next = POSITION_WIDTH'(cfg_wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            prev_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
            prev_reg <= prev_next;
        end
    end

endmodule : odve_front
`default_nettype wire

// ===== sv/odve_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// odve_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module odve_queue
    import odve_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire enc_entry_t    push_entry,
    input  wire logic          pop,
    output      enc_entry_t    pop_entry,
    output      queue_status_t status
);

    enc_entry_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_entry    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        do_push     = push && !status.full;
        do_pop      = pop && !status.empty;
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : odve_queue
`default_nettype wire

// ===== sv/odve_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// odve_back
// Takes classified items from the queue, sending a byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module odve_back
    import odve_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire queue_status_t q_status,
    input  wire enc_entry_t    q_pop_entry,
    output      logic          q_pop,
    output      logic          out_valid,
    input  wire logic          out_stall,
    output      out_beat_t     out_beat
);

    logic                  busy_reg;
    logic                  busy_next;
    enc_kind_t             kind_reg;
    enc_kind_t             kind_next;
    logic [QUOT_WIDTH-1:0] quot_reg;
    logic [QUOT_WIDTH-1:0] quot_next;
    logic [1:0]            idx_reg;
    logic [1:0]            idx_next;
    logic                  load;

    assign out_valid = busy_reg;

    always_comb
    begin
        out_beat.range_error = 1'b0;
        out_beat.last_byte   = 1'b0;
        out_beat.table_byte  = 8'h00;
        case (kind_reg)
            KIND_ONE:
            begin
                out_beat.table_byte = {MARK_ONE, quot_reg[5:0]};
                out_beat.last_byte  = 1'b1;
            end
            KIND_TWO:
            begin
                if (idx_reg == 2'd0)
                begin
                    out_beat.table_byte = {MARK_TWO, quot_reg[13:8]};
                end
                else
                begin
                    out_beat.table_byte = quot_reg[7:0];
                    out_beat.last_byte  = 1'b1;
                end
            end
            KIND_FOUR:
            begin
                case (idx_reg)
                    2'd0:    out_beat.table_byte = {MARK_FOUR, quot_reg[29:24]};
                    2'd1:    out_beat.table_byte = quot_reg[23:16];
                    2'd2:    out_beat.table_byte = quot_reg[15:8];
                    default:
                    begin
                        out_beat.table_byte = quot_reg[7:0];
                        out_beat.last_byte  = 1'b1;
                    end
                endcase
            end
            default:
            begin
                out_beat.last_byte   = 1'b1;
                out_beat.range_error = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        // A new item is loaded when nothing is held, or as the final byte
        // of the current one is taken.
        load      = !busy_reg || (!out_stall && out_beat.last_byte);
        q_pop     = load && !q_status.empty;
        busy_next = busy_reg;
        kind_next = kind_reg;
        quot_next = quot_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = !q_status.empty;
            kind_next = q_pop_entry.kind;
            quot_next = q_pop_entry.quotient;
            idx_next  = 2'd0;
        end
        else if (!out_stall)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        quot_reg <= quot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule : odve_back
`default_nettype wire
